FILE: rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int CharW = 7;
  localparam int ShiftW = 8;
  localparam int CntW = 3;

  localparam logic [CharW-1:0] SUBST_CHAR = 7'd48;
  localparam logic [CharW-1:0] SYNC_RESET = 7'd22;
  localparam logic [CharW-1:0] END_RESET = 7'd10;
  localparam logic [CntW-1:0] LAST_BIT = 3'd7;

  localparam logic CFG_SYNC_CHAR = 1'b0;
  localparam logic CFG_END_CHAR = 1'b1;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             perr;
  } char_t;

  typedef struct packed {
    logic [CharW-1:0] data_char;
    logic             parity_error;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

endpackage

FILE: rtl/sfr_front.sv
module sfr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_line_bit,
  output logic          in_full,
  input  logic          cq_full,
  output logic          cq_push,
  output sfr_pkg::char_t cq_wdata
);
  import sfr_pkg::*;

  logic [ShiftW-1:0] bit_shift_r, bit_shift_nxt;
  logic [CntW-1:0]   bit_count_r, bit_count_nxt;
  logic [ShiftW-1:0] shifted;
  logic              accept;
  logic              perr;

  assign in_full = (bit_count_r == LAST_BIT) && cq_full;
  assign accept = in_push && !in_full;
  assign shifted = {in_line_bit, bit_shift_r[ShiftW-1:1]};
  // odd parity passes when the xor of all eight bits is one
  assign perr = ~(^shifted);

  assign cq_push = accept && (bit_count_r == LAST_BIT);
  assign cq_wdata.perr = perr;
  assign cq_wdata.ch = perr ? SUBST_CHAR : shifted[CharW-1:0];

  always_comb begin
    bit_shift_nxt = bit_shift_r;
    bit_count_nxt = bit_count_r;
    if (accept) begin
      if (bit_count_r == LAST_BIT) begin
        bit_shift_nxt = '0;
        bit_count_nxt = '0;
      end else begin
        bit_shift_nxt = shifted;
        bit_count_nxt = bit_count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_shift_r <= '0;
      bit_count_r <= '0;
    end else begin
      bit_shift_r <= bit_shift_nxt;
      bit_count_r <= bit_count_nxt;
    end
  end

endmodule

FILE: rtl/sfr_char_q.sv
module sfr_char_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfr_pkg::char_t wdata,
  input  logic           pop,
  output sfr_pkg::char_t rdata,
  output logic           full,
  output logic           empty
);
  import sfr_pkg::*;

  char_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/sfr_back.sv
module sfr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sfr_pkg::CharW-1:0]   cfg_wdata,
  input  logic                        cq_empty,
  input  sfr_pkg::char_t              cq_rdata,
  output logic                        cq_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [sfr_pkg::CharW-1:0]   out_data_char,
  output logic                        out_parity_error,
  output logic                        out_frame_last
);
  import sfr_pkg::*;

  typedef enum logic [1:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN,
    PH_DATA
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CharW-1:0] remain_r, remain_nxt;
  logic [CharW-1:0] sync_char_r, end_char_r;
  logic [CharW-1:0] remain_dec;

  result_t    oq_mem_r [2];
  result_t    res;
  logic       res_push;
  q_ctl_t     oq;
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;

  assign oq.full = oq_cnt_r == 2'd2;
  assign oq.empty = oq_cnt_r == 2'd0;
  assign oq.push = res_push;
  assign oq.pop = out_pop && !oq.empty;

  assign cq_pop = !cq_empty && !oq.full;
  assign remain_dec = remain_r - 7'd1;

  always_comb begin
    phase_nxt = phase_r;
    remain_nxt = remain_r;
    res_push = 1'b0;
    res.data_char = cq_rdata.ch;
    res.parity_error = cq_rdata.perr;
    res.frame_last = remain_dec == '0;
    if (cq_pop) begin
      unique case (phase_r)
        PH_SYNC1: begin
          phase_nxt = (cq_rdata.ch == sync_char_r) ? PH_SYNC2 : PH_SYNC1;
        end
        PH_SYNC2: begin
          phase_nxt = (cq_rdata.ch == sync_char_r) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          remain_nxt = cq_rdata.ch;
          phase_nxt = (cq_rdata.ch == '0) ? PH_SYNC1 : PH_DATA;
        end
        PH_DATA: begin
          if (cq_rdata.ch == end_char_r || remain_r == '0) begin
            remain_nxt = '0;
            phase_nxt = PH_SYNC1;
          end else begin
            remain_nxt = remain_dec;
            res_push = 1'b1;
            if (remain_dec == '0) begin
              phase_nxt = PH_SYNC1;
            end
          end
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq.push && !oq.pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq.pop && !oq.push) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  assign out_empty = oq.empty;
  assign out_data_char = oq_mem_r[oq_rd_r].data_char;
  assign out_parity_error = oq_mem_r[oq_rd_r].parity_error;
  assign out_frame_last = oq_mem_r[oq_rd_r].frame_last;

  always_ff @(posedge clk) begin
    if (oq.push) begin
      oq_mem_r[oq_wr_r] <= res;
    end
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      remain_r <= '0;
      sync_char_r <= SYNC_RESET;
      end_char_r <= END_RESET;
      oq_wr_r <= 1'b0;
      oq_rd_r <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      remain_r <= remain_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SYNC_CHAR: sync_char_r <= cfg_wdata;
          CFG_END_CHAR:  end_char_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (oq.push) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq.pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule

FILE: rtl/sync_frame_receiver_odd_parity_core.sv
// Serial character deframer: takes one line bit per cycle on in_push/in_full, assembles
// eight bits (first bit received as the lsb) into a character, checks odd parity, then
// hunts for two sync characters, a length and up to that many data characters, each data
// word appearing on the out_ side as a queue entry. A bit is taken every cycle while
// in_full is low; in_full rises only on the eighth bit of a character while the two-entry
// character queue between the bit assembler and the frame sequencer is full. That queue
// fills only after the two-entry result queue has stayed full with out_pop low, and in_full
// falls once the next pop frees a result entry and the sequencer then pops that queue.
// A data word reaches out_ through the character and result queue registers and can
// be popped once shown there. cfg_index 0 writes the sync character, 1 the end character.
module sync_frame_receiver_odd_parity_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_line_bit,
  output logic                      in_full,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [sfr_pkg::CharW-1:0] out_data_char,
  output logic                      out_parity_error,
  output logic                      out_frame_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [sfr_pkg::CharW-1:0] cfg_wdata
);
  import sfr_pkg::*;

  char_t cq_wdata, cq_rdata;
  logic  cq_push, cq_pop, cq_full, cq_empty;

  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_line_bit(in_line_bit),
    .in_full    (in_full),
    .cq_full    (cq_full),
    .cq_push    (cq_push),
    .cq_wdata   (cq_wdata)
  );

  sfr_char_q u_char_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .wdata(cq_wdata),
    .pop  (cq_pop),
    .rdata(cq_rdata),
    .full (cq_full),
    .empty(cq_empty)
  );

  sfr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cq_empty        (cq_empty),
    .cq_rdata        (cq_rdata),
    .cq_pop          (cq_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_data_char   (out_data_char),
    .out_parity_error(out_parity_error),
    .out_frame_last  (out_frame_last)
  );

endmodule

FILE: rtl/sfr_checker.sv
module sfr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_full,
  input logic                      out_pop,
  input logic                      out_empty,
  input logic [sfr_pkg::CharW-1:0] out_data_char,
  input logic                      out_parity_error
);
  import sfr_pkg::*;

  // reset leaves no word waiting and room for a bit
  a_reset_clean: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not clear after reset");

  // back-pressure on bits only while results are held
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input stalled with no result waiting");

  // a parity failure always carries the substitute character
  a_subst: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_parity_error |-> out_data_char == SUBST_CHAR)
    else $error("parity error without substitute character");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data_char))
    else $error("waiting word changed before pop");

endmodule

bind sync_frame_receiver_odd_parity_core sfr_checker u_sfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_pop         (out_pop),
  .out_empty       (out_empty),
  .out_data_char   (out_data_char),
  .out_parity_error(out_parity_error)
);
